// ===== sv/ilis_pkg.sv =====
// Package: shared types and constants for the item list with insertion sort.
`default_nettype none
package ilis_pkg;
  localparam int MAX_ITEMS = 32;
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int IW = AW + 1;

  localparam logic [2:0] REQ_APPEND  = 3'd0;
  localparam logic [2:0] REQ_PUSH_HD = 3'd1;
  localparam logic [2:0] REQ_POP_HD  = 3'd2;
  localparam logic [2:0] REQ_POP_TL  = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;
  localparam logic [2:0] REQ_SORT    = 3'd5;
  localparam logic [2:0] REQ_DUMP    = 3'd6;
  // spare code, dropped without a result
  localparam logic [2:0] REQ_UNUSED  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] price;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        entry_id;
    logic signed [31:0] entry_price;
    logic [5:0]         entry_count;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] price;
  } entry_t;
endpackage
`default_nettype wire

// ===== sv/ilis_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module ilis_ram #(
  parameter int DW    = 48,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/item_list_with_insertion_sort.sv =====
// Top level: ordered list of priced entries kept in a circular RAM, with insertion sort.
`default_nettype none
// The list lives in one RAM of MAX_ITEMS {id, price} entries used as a ring:
// head_r marks the first entry, so inserting or removing at either end is a
// single write or a pointer move. Commands are taken one at a time. Append,
// insert head, remove head/tail and clear finish in the accept cycle; the
// result beat sits in the output register and the next command may be
// accepted as that beat leaves. Sort is an insertion sort run against the
// RAM with its registered read data: each outer step fetches the key, then
// shifts one entry per compare while the entry before it is greater, then
// places the key. Dump reads one entry at a time, one beat per entry,
// stalling on out_ready.
// Ids come from a 16-bit counter that is not touched by clear.
// A command code of 7 is dropped without a result.
module item_list_with_insertion_sort (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ilis_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ilis_pkg::out_beat_t     out_data
);
  localparam int AW = ilis_pkg::AW;
  localparam int IW = ilis_pkg::IW;
  localparam logic [IW-1:0] MAXI = IW'(ilis_pkg::MAX_ITEMS);

  typedef enum logic [2:0] {
    S_IDLE, S_SORT_RD, S_SORT_KEY, S_SORT_CMP, S_SORT_PUT, S_SORT_DONE,
    S_DUMP_RD, S_DUMP_EMIT
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       head_r;
  logic [IW-1:0]       count_r;
  logic [15:0]         next_id_r;
  logic [IW-1:0]       i_r, j_r;
  ilis_pkg::entry_t    key_r;
  logic                out_valid_r;
  ilis_pkg::out_beat_t out_r;

  // RAM ports
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  ilis_pkg::entry_t wdata, rdata;

  logic          out_free, acc, full, empty, greater;
  logic [AW-1:0] head_m1;
  logic [15:0]   new_id;

  // Logical position to RAM address, wrapping around the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [IW-1:0] l);
    logic [IW:0] s;
    s = {2'b00, hd} + {1'b0, l};
    if (s >= (IW+1)'(ilis_pkg::MAX_ITEMS)) begin
      s = s - (IW+1)'(ilis_pkg::MAX_ITEMS);
    end
    return s[AW-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign full     = (count_r >= MAXI);
  assign empty    = (count_r == '0);
  assign head_m1  = (head_r == '0) ? AW'(ilis_pkg::MAX_ITEMS - 1) : head_r - AW'(1);
  assign new_id   = next_id_r + 16'd1;
  assign greater  = (rdata.price > key_r.price);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    we    = 1'b0;
    waddr = phys(head_r, count_r);
    wdata = '{id: new_id, price: in_data.price};
    raddr = phys(head_r, i_r);
    unique case (state_r)
      S_IDLE: begin
        if (acc && !full && in_data.req_type == ilis_pkg::REQ_APPEND) begin
          we = 1'b1;
        end else if (acc && !full && in_data.req_type == ilis_pkg::REQ_PUSH_HD) begin
          we    = 1'b1;
          waddr = head_m1;
        end
      end
      S_SORT_KEY: raddr = phys(head_r, j_r - IW'(1));
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = phys(head_r, j_r);
        if (greater) begin
          wdata = rdata;
          raddr = phys(head_r, j_r - IW'(2));
        end else begin
          wdata = key_r;
        end
      end
      S_SORT_PUT: begin
        we    = 1'b1;
        waddr = head_r;
        wdata = key_r;
      end
      default: ;
    endcase
  end

  ilis_ram #(.DW($bits(ilis_pkg::entry_t)), .DEPTH(ilis_pkg::MAX_ITEMS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc && in_data.req_type != ilis_pkg::REQ_UNUSED) begin
            // default single-beat result, fields patched per command
            out_valid_r       <= 1'b1;
            out_r.status      <= ilis_pkg::ST_OK;
            out_r.entry_id    <= '0;
            out_r.entry_price <= '0;
            out_r.entry_count <= 6'(count_r);
            out_r.last        <= 1'b1;
            i_r               <= IW'(1);
            j_r               <= IW'(1);
            case (in_data.req_type)
              ilis_pkg::REQ_APPEND, ilis_pkg::REQ_PUSH_HD: begin
                if (full) begin
                  out_r.status <= ilis_pkg::ST_FULL;
                end else begin
                  next_id_r         <= new_id;
                  count_r           <= count_r + IW'(1);
                  out_r.entry_id    <= new_id;
                  out_r.entry_count <= 6'(count_r + IW'(1));
                  if (in_data.req_type == ilis_pkg::REQ_PUSH_HD) begin
                    head_r <= head_m1;
                  end
                end
              end
              ilis_pkg::REQ_POP_HD, ilis_pkg::REQ_POP_TL: begin
                if (empty) begin
                  out_r.status <= ilis_pkg::ST_EMPTY;
                end else begin
                  count_r           <= count_r - IW'(1);
                  out_r.entry_count <= 6'(count_r - IW'(1));
                  if (in_data.req_type == ilis_pkg::REQ_POP_HD) begin
                    head_r <= phys(head_r, IW'(1));
                  end
                end
              end
              ilis_pkg::REQ_CLEAR: begin
                count_r           <= '0;
                out_r.entry_count <= '0;
              end
              ilis_pkg::REQ_SORT: begin
                if (empty) begin
                  out_r.status <= ilis_pkg::ST_EMPTY;
                end else if (count_r != IW'(1)) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_SORT_RD;
                end
              end
              ilis_pkg::REQ_DUMP: begin
                if (empty) begin
                  out_r.status <= ilis_pkg::ST_EMPTY;
                end else begin
                  out_valid_r <= 1'b0;
                  i_r         <= '0;
                  state_r     <= S_DUMP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SORT_RD: begin
          j_r     <= i_r;
          state_r <= S_SORT_KEY;
        end
        S_SORT_KEY: begin
          key_r   <= rdata;
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (greater) begin
            j_r <= j_r - IW'(1);
            if (j_r == IW'(1)) begin
              state_r <= S_SORT_PUT;
            end
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= (i_r + IW'(1) < count_r) ? S_SORT_RD : S_SORT_DONE;
          end
        end
        S_SORT_PUT: begin
          i_r     <= i_r + IW'(1);
          state_r <= (i_r + IW'(1) < count_r) ? S_SORT_RD : S_SORT_DONE;
        end
        S_SORT_DONE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.status      <= ilis_pkg::ST_OK;
            out_r.entry_id    <= '0;
            out_r.entry_price <= '0;
            out_r.entry_count <= 6'(count_r);
            out_r.last        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_DUMP_RD: state_r <= S_DUMP_EMIT;
        S_DUMP_EMIT: begin
          // raddr still points at entry i, so rdata holds while stalled
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.status      <= ilis_pkg::ST_OK;
            out_r.entry_id    <= rdata.id;
            out_r.entry_price <= rdata.price;
            out_r.entry_count <= 6'(count_r);
            out_r.last        <= (i_r + IW'(1) == count_r);
            i_r               <= i_r + IW'(1);
            state_r           <= (i_r + IW'(1) == count_r) ? S_IDLE : S_DUMP_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= MAXI)
    else $error("entry count above capacity");
  a_sort_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.req_type == ilis_pkg::REQ_SORT && count_r > IW'(1) |=> !in_ready)
    else $error("command accepted during sort");
  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    we && state_r != S_IDLE |-> j_r <= i_r && i_r < count_r)
    else $error("sort write outside active list");
  a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP_EMIT && !out_free |=> state_r == S_DUMP_EMIT && $stable(i_r))
    else $error("dump moved while stalled");
`endif
endmodule
`default_nettype wire
